/* hw/rtl/assert_macros.svh */
// assertion helpers, compiled out for synthesis
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

`define ASSERT_IMPLY(label, clk, rst_n, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
		else $error(msg);

`else

`define ASSERT_ALWAYS(label, clk, rst_n, cond, msg)

`define ASSERT_IMPLY(label, clk, rst_n, pre, post, msg)

`endif

`endif

/* hw/rtl/blh_pkg.sv */
package blh_pkg;

	localparam int unsigned MV_W = 13;
	localparam int unsigned REG_IDX_W = 3;
	localparam int unsigned APB_ADDR_W = 5;
	localparam int unsigned APB_DATA_W = 32;
	localparam int unsigned IN_TDATA_W = 16;
	localparam int unsigned OUT_TDATA_W = 8;

	typedef logic [MV_W-1:0] mv_t;

	typedef enum logic [2:0] {
		LVL_UNDEF = 3'd0,
		LVL_EMPTY = 3'd1,
		LVL_ONE   = 3'd2,
		LVL_TWO   = 3'd3,
		LVL_THREE = 3'd4,
		LVL_FOUR  = 3'd5
	} lvl_t;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_CHARGE_L1 = 3'd0,
		REG_CHARGE_L2 = 3'd1,
		REG_CHARGE_L3 = 3'd2,
		REG_CHARGE_L4 = 3'd3,
		REG_DRAIN_L3  = 3'd4,
		REG_DRAIN_L2  = 3'd5,
		REG_DRAIN_L1  = 3'd6,
		REG_DRAIN_E   = 3'd7
	} reg_idx_t;

	localparam mv_t RST_CHARGE_L1 = 13'd3100;
	localparam mv_t RST_CHARGE_L2 = 13'd3430;
	localparam mv_t RST_CHARGE_L3 = 13'd3770;
	localparam mv_t RST_CHARGE_L4 = 13'd4100;
	localparam mv_t RST_DRAIN_L3  = 13'd4000;
	localparam mv_t RST_DRAIN_L2  = 13'd3670;
	localparam mv_t RST_DRAIN_L1  = 13'd3330;
	localparam mv_t RST_DRAIN_E   = 13'd3000;

	typedef struct packed {
		mv_t charge_l1;
		mv_t charge_l2;
		mv_t charge_l3;
		mv_t charge_l4;
		mv_t drain_l3;
		mv_t drain_l2;
		mv_t drain_l1;
		mv_t drain_e;
	} thr_t;

	typedef struct packed {
		logic became_empty;
		logic became_good;
		lvl_t level;
	} step_t;

endpackage

/* hw/rtl/battery_level_hysteresis_unit.sv */
// channel  | dir | signals                         | content
// s_axis   | in  | tvalid tready tdata[15:0]       | voltage_mv
// m_axis   | out | tvalid tready tdata[7:0]        | level, became_good, became_empty
// apb      | in  | psel penable pwrite paddr pwdata | eight 13-bit thresholds at 4*i
//
// a sample passes from the input transfer through the input register, then through the level update
// into the result register that drives m_axis
// one sample per clock sustained while m_axis accepts; the level register feeds the next sample's update
// reset clears both stage valids, sets the level to undefined and loads default thresholds
// a stalled m_axis holds its result while one more sample waits in the input register
`include "assert_macros.svh"

module battery_level_hysteresis_unit (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_axis_tvalid,
	output logic                           s_axis_tready,
	input  logic [blh_pkg::IN_TDATA_W-1:0]  s_axis_tdata,  // [12:0] voltage_mv
	output logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	output logic [blh_pkg::OUT_TDATA_W-1:0] m_axis_tdata,  // [2:0] level, [3] became_good, [4] became_empty
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [blh_pkg::APB_ADDR_W-1:0]  paddr,
	input  logic [blh_pkg::APB_DATA_W-1:0]  pwdata,
	output logic [blh_pkg::APB_DATA_W-1:0]  prdata,
	output logic                           pready
);
	import blh_pkg::*;

	thr_t  thr;
	step_t res;

	blh_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.thr     (thr)
	);

	blh_pipe u_pipe (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_mv     (s_axis_tdata[MV_W-1:0]),
		.thr       (thr),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_step  (res)
	);

	assign m_axis_tdata = {3'b000, res.became_empty, res.became_good, res.level};

	`ASSERT_IMPLY(a_level_range, clk, arst_n, m_axis_tvalid, res.level <= LVL_FOUR, "level code out of range")
	`ASSERT_IMPLY(a_flags_exclusive, clk, arst_n, m_axis_tvalid, !(res.became_good && res.became_empty), "both event flags set")
	`ASSERT_IMPLY(a_empty_flag_level, clk, arst_n, m_axis_tvalid && res.became_empty, res.level == LVL_EMPTY, "shutdown flag without empty level")
	`ASSERT_IMPLY(a_ready_when_drained, clk, arst_n, !m_axis_tvalid, s_axis_tready, "input stalled with empty output")

endmodule

/* hw/rtl/blh_cfg_regs.sv */
module blh_cfg_regs (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [blh_pkg::APB_ADDR_W-1:0] paddr,
	input  logic [blh_pkg::APB_DATA_W-1:0] pwdata,
	output logic [blh_pkg::APB_DATA_W-1:0] prdata,
	output logic                          pready,
	output blh_pkg::thr_t                 thr
);
	import blh_pkg::*;

	thr_t     thr_q;
	reg_idx_t idx;
	logic     wr_en;
	mv_t      wr_mv;
	mv_t      rd_mv;

	assign idx    = reg_idx_t'(paddr[APB_ADDR_W-1:2]);
	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;
	assign wr_mv  = pwdata[MV_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q.charge_l1 <= RST_CHARGE_L1;
			thr_q.charge_l2 <= RST_CHARGE_L2;
			thr_q.charge_l3 <= RST_CHARGE_L3;
			thr_q.charge_l4 <= RST_CHARGE_L4;
			thr_q.drain_l3  <= RST_DRAIN_L3;
			thr_q.drain_l2  <= RST_DRAIN_L2;
			thr_q.drain_l1  <= RST_DRAIN_L1;
			thr_q.drain_e   <= RST_DRAIN_E;
		end else if (wr_en) begin
			unique case (idx)
				REG_CHARGE_L1: thr_q.charge_l1 <= wr_mv;
				REG_CHARGE_L2: thr_q.charge_l2 <= wr_mv;
				REG_CHARGE_L3: thr_q.charge_l3 <= wr_mv;
				REG_CHARGE_L4: thr_q.charge_l4 <= wr_mv;
				REG_DRAIN_L3:  thr_q.drain_l3  <= wr_mv;
				REG_DRAIN_L2:  thr_q.drain_l2  <= wr_mv;
				REG_DRAIN_L1:  thr_q.drain_l1  <= wr_mv;
				REG_DRAIN_E:   thr_q.drain_e   <= wr_mv;
				default:       thr_q           <= thr_q;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_CHARGE_L1: rd_mv = thr_q.charge_l1;
			REG_CHARGE_L2: rd_mv = thr_q.charge_l2;
			REG_CHARGE_L3: rd_mv = thr_q.charge_l3;
			REG_CHARGE_L4: rd_mv = thr_q.charge_l4;
			REG_DRAIN_L3:  rd_mv = thr_q.drain_l3;
			REG_DRAIN_L2:  rd_mv = thr_q.drain_l2;
			REG_DRAIN_L1:  rd_mv = thr_q.drain_l1;
			REG_DRAIN_E:   rd_mv = thr_q.drain_e;
			default:       rd_mv = '0;
		endcase
	end

	assign prdata = {{(APB_DATA_W-MV_W){1'b0}}, rd_mv};
	assign thr    = thr_q;

endmodule

/* hw/rtl/blh_level_next.sv */
module blh_level_next (
	input  blh_pkg::lvl_t  cur,
	input  blh_pkg::mv_t   voltage_mv,
	input  blh_pkg::thr_t  thr,
	output blh_pkg::step_t step
);
	import blh_pkg::*;

	lvl_t nxt;

	always_comb begin
		nxt = cur;
		unique case (cur)
			LVL_UNDEF: begin
				priority if (voltage_mv < thr.drain_e)   nxt = LVL_EMPTY;
				else if (voltage_mv < thr.charge_l2)     nxt = LVL_ONE;
				else if (voltage_mv < thr.charge_l3)     nxt = LVL_TWO;
				else if (voltage_mv < thr.charge_l4)     nxt = LVL_THREE;
				else                                     nxt = LVL_FOUR;
			end
			LVL_EMPTY: begin
				if (voltage_mv >= thr.charge_l1) nxt = LVL_ONE;
			end
			LVL_ONE: begin
				// rise wins over fall
				priority if (voltage_mv >= thr.charge_l2) nxt = LVL_TWO;
				else if (voltage_mv < thr.drain_e)        nxt = LVL_EMPTY;
			end
			LVL_TWO: begin
				priority if (voltage_mv >= thr.charge_l3) nxt = LVL_THREE;
				else if (voltage_mv < thr.drain_l1)       nxt = LVL_ONE;
			end
			LVL_THREE: begin
				priority if (voltage_mv >= thr.charge_l4) nxt = LVL_FOUR;
				else if (voltage_mv < thr.drain_l2)       nxt = LVL_TWO;
			end
			LVL_FOUR: begin
				if (voltage_mv < thr.drain_l3) nxt = LVL_THREE;
			end
			default: nxt = cur;
		endcase
	end

	assign step.level        = nxt;
	assign step.became_good  = (cur == LVL_UNDEF || cur == LVL_EMPTY) && nxt != LVL_EMPTY;
	assign step.became_empty = cur != LVL_EMPTY && nxt == LVL_EMPTY;

endmodule

/* hw/rtl/blh_pipe.sv */
module blh_pipe (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  blh_pkg::mv_t   in_mv,
	input  blh_pkg::thr_t  thr,
	output logic           out_valid,
	input  logic           out_ready,
	output blh_pkg::step_t out_step
);
	import blh_pkg::*;

	logic  vld_s1;
	mv_t   mv_s1;
	logic  vld_s2;
	step_t step_s2;
	lvl_t  level_q;
	step_t step_nxt;
	logic  adv;

	assign adv      = vld_s1 && (!vld_s2 || out_ready);
	assign in_ready = !vld_s1 || adv;

	blh_level_next u_next (
		.cur        (level_q),
		.voltage_mv (mv_s1),
		.thr        (thr),
		.step       (step_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1  <= 1'b0;
			vld_s2  <= 1'b0;
			level_q <= LVL_UNDEF;
		end else begin
			if (in_valid && in_ready) begin
				vld_s1 <= 1'b1;
			end else if (adv) begin
				vld_s1 <= 1'b0;
			end
			if (adv) begin
				vld_s2  <= 1'b1;
				level_q <= step_nxt.level;
			end else if (out_ready) begin
				vld_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			mv_s1 <= in_mv;
		end
		if (adv) begin
			step_s2 <= step_nxt;
		end
	end

	assign out_valid = vld_s2;
	assign out_step  = step_s2;

endmodule

/* tb/blh_checker.sv */
`timescale 1ns / 100ps

module blh_checker (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_axis_tvalid,
	input  logic                           s_axis_tready,
	input  logic [blh_pkg::IN_TDATA_W-1:0]  s_axis_tdata,  // [12:0] voltage_mv
	input  logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	input  logic [blh_pkg::OUT_TDATA_W-1:0] m_axis_tdata,  // [2:0] level, [3] became_good, [4] became_empty
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [blh_pkg::APB_ADDR_W-1:0]  paddr,
	input  logic [blh_pkg::APB_DATA_W-1:0]  pwdata,
	input  logic                           pready,
	output int                             fail_count,
	output int                             outstanding,
	output int                             checked
);

	import blh_pkg::*;

	thr_t  thr;
	lvl_t  level_now;
	step_t level_q[$];
	int    n_fail = 0;
	int    n_checked = 0;

	function automatic step_t next_level_step(input lvl_t cur, input mv_t v, input thr_t t);
		step_t r;
		lvl_t  nxt;
		nxt = cur;
		case (cur)
			LVL_UNDEF: begin
				if (v < t.drain_e)
					nxt = LVL_EMPTY;
				else if (v < t.charge_l2)
					nxt = LVL_ONE;
				else if (v < t.charge_l3)
					nxt = LVL_TWO;
				else if (v < t.charge_l4)
					nxt = LVL_THREE;
				else
					nxt = LVL_FOUR;
			end
			LVL_EMPTY: begin
				if (v >= t.charge_l1)
					nxt = LVL_ONE;
			end
			// a rise is tested first, so it wins when both thresholds are met
			LVL_ONE: begin
				if (v >= t.charge_l2)
					nxt = LVL_TWO;
				else if (v < t.drain_e)
					nxt = LVL_EMPTY;
			end
			LVL_TWO: begin
				if (v >= t.charge_l3)
					nxt = LVL_THREE;
				else if (v < t.drain_l1)
					nxt = LVL_ONE;
			end
			LVL_THREE: begin
				if (v >= t.charge_l4)
					nxt = LVL_FOUR;
				else if (v < t.drain_l2)
					nxt = LVL_TWO;
			end
			LVL_FOUR: begin
				if (v < t.drain_l3)
					nxt = LVL_THREE;
			end
			default: nxt = cur;
		endcase
		r.level = nxt;
		r.became_good = (cur == LVL_UNDEF || cur == LVL_EMPTY) && nxt != LVL_EMPTY;
		r.became_empty = cur != LVL_EMPTY && nxt == LVL_EMPTY;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin : monitor
		step_t want;
		step_t got;
		if (!arst_n) begin
			thr = '{RST_CHARGE_L1, RST_CHARGE_L2, RST_CHARGE_L3, RST_CHARGE_L4,
				RST_DRAIN_L3, RST_DRAIN_L2, RST_DRAIN_L1, RST_DRAIN_E};
			level_now = LVL_UNDEF;
			level_q.delete();
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (reg_idx_t'(paddr[APB_ADDR_W-1:2]))
					REG_CHARGE_L1: thr.charge_l1 = pwdata[MV_W-1:0];
					REG_CHARGE_L2: thr.charge_l2 = pwdata[MV_W-1:0];
					REG_CHARGE_L3: thr.charge_l3 = pwdata[MV_W-1:0];
					REG_CHARGE_L4: thr.charge_l4 = pwdata[MV_W-1:0];
					REG_DRAIN_L3:  thr.drain_l3 = pwdata[MV_W-1:0];
					REG_DRAIN_L2:  thr.drain_l2 = pwdata[MV_W-1:0];
					REG_DRAIN_L1:  thr.drain_l1 = pwdata[MV_W-1:0];
					REG_DRAIN_E:   thr.drain_e = pwdata[MV_W-1:0];
					default: ;
				endcase
			end

			if (m_axis_tvalid && m_axis_tready) begin
				got = step_t'(m_axis_tdata[$bits(step_t)-1:0]);
				if (level_q.size() == 0) begin
					$error("result transfer with no sample pending, tdata %h", m_axis_tdata);
					n_fail++;
				end else begin
					want = level_q.pop_front();
					n_checked++;
					if (got.level != want.level) begin
						$error("level: expected %0d, actual %0d", want.level, got.level);
						n_fail++;
					end
					if (got.became_good != want.became_good) begin
						$error("became_good: expected %0d, actual %0d",
							want.became_good, got.became_good);
						n_fail++;
					end
					if (got.became_empty != want.became_empty) begin
						$error("became_empty: expected %0d, actual %0d",
							want.became_empty, got.became_empty);
						n_fail++;
					end
				end
			end

			if (s_axis_tvalid && s_axis_tready) begin
				want = next_level_step(level_now, s_axis_tdata[MV_W-1:0], thr);
				level_now = want.level;
				level_q.push_back(want);
			end
		end
		fail_count <= n_fail;
		outstanding <= level_q.size();
		checked <= n_checked;
	end

endmodule

/* tb/tb_battery_level_hysteresis_unit.sv */
`timescale 1ns / 100ps

module tb_battery_level_hysteresis_unit;

	import blh_pkg::*;

	localparam int IDLE_LIMIT = 400;
	localparam int N_SETTINGS = 10;
	localparam int PER_SETTING = 185;
	localparam mv_t DIRECTED_MV [20] = '{
		13'd0, 13'd3099, 13'd3100, 13'd8191, 13'd8191, 13'd8191, 13'd4000, 13'd3999,
		13'd3669, 13'd3329, 13'd2999, 13'd3100, 13'd3430, 13'd3770, 13'd4100, 13'd0,
		13'd0, 13'd0, 13'd0, 13'd8191
	};

	logic                   clk = 1'b0;
	logic                   arst_n;
	logic                   s_axis_tvalid;
	logic                   s_axis_tready;
	logic [IN_TDATA_W-1:0]  s_axis_tdata;   // [12:0] voltage_mv
	logic                   m_axis_tvalid;
	logic                   m_axis_tready;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;   // [2:0] level, [3] became_good, [4] became_empty
	logic                   psel;
	logic                   penable;
	logic                   pwrite;
	logic [APB_ADDR_W-1:0]  paddr;
	logic [APB_DATA_W-1:0]  pwdata;
	logic [APB_DATA_W-1:0]  prdata;
	logic                   pready;

	int  fail_count;
	int  outstanding;
	int  checked;
	int  sent = 0;
	int  settings = 1;
	int  idle_cycles = 0;
	int  src_run = 0;
	bit  src_steady = 1'b0;
	int  snk_run = 0;
	bit  snk_steady = 1'b0;
	mv_t thr_val [8];
	mv_t next_thr [8];

	always #5 clk = ~clk;

	battery_level_hysteresis_unit u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready)
	);

	blh_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.pready        (pready),
		.fail_count    (fail_count),
		.outstanding   (outstanding),
		.checked       (checked)
	);

	// alternate stretches of back-to-back traffic with stretches of random waits
	function automatic int draw_wait(inout int run_left, inout bit steady);
		if (run_left == 0) begin
			steady = ($urandom_range(0, 2) == 0);
			run_left = steady ? $urandom_range(20, 60) : $urandom_range(10, 40);
		end
		run_left--;
		return steady ? 0 : $urandom_range(0, 14);
	endfunction

	task automatic send_sample(input mv_t v);
		int gap;
		gap = draw_wait(src_run, src_steady);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {{(IN_TDATA_W - MV_W){1'b0}}, v};
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		sent++;
	endtask

	task automatic settle();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic apply_setting();
		for (int i = 0; i < 8; i++) begin
			psel <= 1'b1;
			penable <= 1'b0;
			pwrite <= 1'b1;
			paddr <= {reg_idx_t'(i), 2'b00};
			pwdata <= {(APB_DATA_W - MV_W)'($urandom_range(0, (1 << (APB_DATA_W - MV_W)) - 1)),
				next_thr[i]};
			@(posedge clk);
			penable <= 1'b1;
			@(posedge clk);
			thr_val[i] = next_thr[i];
		end
		psel <= 1'b0;
		penable <= 1'b0;
		settings++;
	endtask

	initial begin : sink
		int stall;
		m_axis_tready <= 1'b0;
		@(posedge clk);
		forever begin
			stall = draw_wait(snk_run, snk_steady);
			if (stall > 0) begin
				m_axis_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			@(posedge clk);
			while (!m_axis_tvalid) @(posedge clk);
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || psel)
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("watchdog: no transfer for %0d cycles", IDLE_LIMIT);
				$display("status: fail");
				$finish;
			end
		end
	end

	initial begin : stimulus
		reg_idx_t ladder [8];
		int       acc;
		int       x;
		int       pick;
		ladder = '{REG_DRAIN_E, REG_CHARGE_L1, REG_DRAIN_L1, REG_CHARGE_L2,
			REG_DRAIN_L2, REG_CHARGE_L3, REG_DRAIN_L3, REG_CHARGE_L4};
		thr_val[REG_CHARGE_L1] = RST_CHARGE_L1;
		thr_val[REG_CHARGE_L2] = RST_CHARGE_L2;
		thr_val[REG_CHARGE_L3] = RST_CHARGE_L3;
		thr_val[REG_CHARGE_L4] = RST_CHARGE_L4;
		thr_val[REG_DRAIN_L3] = RST_DRAIN_L3;
		thr_val[REG_DRAIN_L2] = RST_DRAIN_L2;
		thr_val[REG_DRAIN_L1] = RST_DRAIN_L1;
		thr_val[REG_DRAIN_E] = RST_DRAIN_E;

		arst_n <= 1'b0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata <= '0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		foreach (DIRECTED_MV[k])
			send_sample(DIRECTED_MV[k]);

		for (int phase = 0; phase < N_SETTINGS; phase++) begin
			if (phase > 0) begin
				settle();
				case (phase)
					1: foreach (next_thr[i]) next_thr[i] = '0;
					2: foreach (next_thr[i]) next_thr[i] = '1;
					3, 4, 5: begin
						// ordered ladder: each drain threshold below its charge threshold
						acc = $urandom_range(0, 4000);
						foreach (ladder[j]) begin
							acc += $urandom_range(1, 500);
							next_thr[ladder[j]] = mv_t'(acc);
						end
					end
					default: begin
						foreach (next_thr[i]) begin
							pick = $urandom_range(0, 9);
							if (pick == 0)
								next_thr[i] = '0;
							else if (pick == 1)
								next_thr[i] = '1;
							else
								next_thr[i] = mv_t'($urandom_range(0, 8191));
						end
					end
				endcase
				apply_setting();
			end
			repeat (PER_SETTING) begin
				pick = $urandom_range(0, 15);
				if (pick < 2)
					x = $urandom_range(0, 8191);
				else if (pick == 2)
					x = $urandom_range(0, 1) ? 8191 : 0;
				else begin
					// mostly just around a threshold in use
					x = int'(thr_val[$urandom_range(0, 7)]) + $urandom_range(0, 3) - 2;
					if (x < 0)
						x = 0;
					if (x > 8191)
						x = 8191;
				end
				send_sample(mv_t'(x));
			end
		end
		settle();

		$display("%0d voltage samples over %0d threshold settings, defaults and extremes included",
			sent, settings);
		$display("%0d level results checked, %0d mismatches", checked, fail_count);
		if (fail_count == 0 && outstanding == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
